// ----- src/stepper_trapezoid_speed_ramp_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stepper speed ramp unit
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef STEPPER_TRAPEZOID_SPEED_RAMP_UNIT_ASSERT_SVH
`define STEPPER_TRAPEZOID_SPEED_RAMP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- src/stsr_pkg.sv -----
// ----------------------------------------------------------------------------
// Stepper speed ramp package
// Shared types and constants of the ramp planner and its serial arithmetic.
// ----------------------------------------------------------------------------
package stsr_pkg;

    // serial arithmetic operand widths
    localparam int AR_A_W = 50;
    localparam int AR_B_W = 43;

    // iteration counts of the serial unit
    localparam logic [5:0] AR_MUL_STEPS  = 6'd17;
    localparam logic [5:0] AR_DIV_STEPS  = 6'd50;
    localparam logic [5:0] AR_SQRT_STEPS = 6'd16;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_DELAY_NUM = 2'd0;
    localparam logic [1:0] REG_FIRST_SCALE   = 2'd1;
    localparam logic [1:0] REG_ROOT_NUM      = 2'd2;
    localparam logic [1:0] REG_ANGLE_20K     = 2'd3;

    // operation codes of the serial unit
    typedef enum logic [1:0] {
        AOP_MUL  = 2'd0,
        AOP_DIV  = 2'd1,
        AOP_SQRT = 2'd2
    } t_aop;

    // ramp phase
    typedef enum logic [3:0] {
        PH_STOP  = 4'b0001,
        PH_ACCEL = 4'b0010,
        PH_RUN   = 4'b0100,
        PH_DECEL = 4'b1000
    } t_phase;

    typedef struct packed {
        logic                start;
        t_aop                op;
        logic [AR_A_W-1:0]   a;
        logic [AR_B_W-1:0]   b;
    } t_arith_req;

    typedef struct packed {
        logic                done;
        logic [AR_A_W-1:0]   q;
        logic [AR_B_W-1:0]   r;
    } t_arith_rsp;

endpackage

// ----- src/stsr_cmd_if.sv -----
// ----------------------------------------------------------------------------
// Command channel
// Move commands and timer ticks with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface stsr_cmd_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] move_steps;
    logic [15:0] accel_rate;
    logic [15:0] decel_rate;
    logic [15:0] max_speed;

    modport source (
        output valid, operation, move_steps, accel_rate, decel_rate, max_speed,
        input  ready
    );
    modport sink (
        input  valid, operation, move_steps, accel_rate, decel_rate, max_speed,
        output ready
    );
endinterface

// ----- src/stsr_res_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Step pulse, direction and next timer period with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface stsr_res_if;
    logic        valid;
    logic        ready;
    logic        step_pulse;
    logic        direction_out;
    logic [15:0] timer_period;
    logic        running;
    logic        bad_command;

    modport source (
        output valid, step_pulse, direction_out, timer_period, running, bad_command,
        input  ready
    );
    modport sink (
        input  valid, step_pulse, direction_out, timer_period, running, bad_command,
        output ready
    );
endinterface

// ----- src/stepper_trapezoid_speed_ramp_unit.sv -----
// ----------------------------------------------------------------------------
// Stepper trapezoid speed ramp unit
// Plans a trapezoidal move and answers timer ticks with the next step period.
// ----------------------------------------------------------------------------
// One beat in, one beat out, one item at a time. All arithmetic runs through
// one bit-serial unit (17 iterations per multiply, 50 per divide, 16 per root),
// and every operation also has a launch and a hand-off around its iterations.
// A move command that plans a ramp runs the whole chain of operations, with one
// more multiply and divide when the brake point comes from the deceleration
// limit; a move with zero or one step, a move rejected for zero speed or
// acceleration, and a tick in stop or run phase or with the timer off use no
// arithmetic; a move rejected because the speed limit divisor rounds to zero
// stops after one multiply and one divide; a tick in accel or decel phase takes
// one divide. A result beat waits in the output register, so the next command
// is taken while it is still pending.
module stepper_trapezoid_speed_ramp_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    stsr_cmd_if.sink    i_cmd,
    stsr_res_if.source  o_res
);
    import stsr_pkg::*;

    `include "stepper_trapezoid_speed_ramp_unit_assert.svh"

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_LMUL = 17'h00002,
        S_LDIV = 17'h00004,
        S_FLR  = 17'h00008,
        S_RDIV = 17'h00010,
        S_SQRT = 17'h00020,
        S_FMUL = 17'h00040,
        S_FDIV = 17'h00080,
        S_SMUL = 17'h00100,
        S_TOP  = 17'h00200,
        S_NMUL = 17'h00400,
        S_ALIM = 17'h00800,
        S_TMUL = 17'h01000,
        S_BDIV = 17'h02000,
        S_MFIN = 17'h04000,
        S_RDLY = 17'h08000,
        S_DONE = 17'h10000
    } t_state;

    // configuration
    logic [31:0] r_min_num, r_fscale, r_root_num, r_angle;

    // ramp state
    t_phase      r_phase;
    logic        r_fwd, r_en;
    logic [15:0] r_cur, r_floor, r_last;
    logic [16:0] r_bstart, r_bneg, r_cnt;
    logic [15:0] r_steps;
    logic [18:0] r_rem;

    // command held during planning
    logic [15:0] r_n, r_acc, r_dec, r_spd;
    logic        r_nfwd;
    logic [41:0] r_lim;
    logic [15:0] r_first;
    logic [31:0] r_top;
    logic [16:0] r_bl;

    // sequencer and result
    t_state      r_state;
    logic        r_launched;
    logic        r_pulse, r_bad;
    logic [15:0] r_period;
    logic        r_out_valid;
    logic        r_o_pulse, r_o_dir, r_o_run, r_o_bad;
    logic [15:0] r_o_period;

    t_arith_req  w_req;
    t_arith_rsp  w_rsp;
    logic        w_compute;
    logic        w_accept;
    logic        w_load;
    logic [15:0] w_n;
    logic [15:0] w_steps1;
    logic [18:0] w_dsig, w_dmag;
    logic [19:0] w_num;
    logic [19:0] w_q20;
    logic [20:0] w_sum;
    logic [15:0] w_nd;

    function automatic logic [15:0] sat16(input logic [AR_A_W-1:0] v);
        sat16 = (v[AR_A_W-1:16] != '0) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic ge_start(input logic [15:0] s, input logic [16:0] b);
        ge_start = $signed({2'b00, s}) >= $signed({b[16], b});
    endfunction

    stsr_arith u_arith (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // handshakes
    assign w_accept      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready   = (r_state == S_IDLE);
    assign w_load        = (r_state == S_DONE) && (!r_out_valid || o_res.ready);
    assign o_res.valid   = r_out_valid;
    assign o_res.step_pulse    = r_o_pulse;
    assign o_res.direction_out = r_o_dir;
    assign o_res.timer_period  = r_o_period;
    assign o_res.running       = r_o_run;
    assign o_res.bad_command   = r_o_bad;

    // step magnitude, ramp divisor and delay recurrence
    always_comb begin
        w_n      = i_cmd.move_steps[15] ? (~i_cmd.move_steps + 16'd1) : i_cmd.move_steps;
        w_steps1 = r_steps + 16'd1;
        w_dsig   = {r_cnt, 2'b01};
        w_dmag   = r_cnt[16] ? (~w_dsig + 19'd1) : w_dsig;
        w_num    = {3'b000, r_cur, 1'b0} + {1'b0, r_rem};
        w_q20    = w_rsp.q[19:0];
        w_sum    = {5'b00000, r_cur} + {1'b0, w_q20};
        if (r_cnt[16]) begin
            w_nd = (w_sum[20:16] != '0) ? 16'hFFFF : w_sum[15:0];
        end else begin
            w_nd = (w_q20 > {4'h0, r_cur}) ? 16'h0000 : (r_cur - w_q20[15:0]);
        end
    end

    // arithmetic requests
    always_comb begin
        w_compute = 1'b1;
        w_req.op  = AOP_DIV;
        w_req.a   = '0;
        w_req.b   = '0;
        unique case (r_state)
            S_LMUL: begin
                w_req.op = AOP_MUL;
                w_req.a  = {18'h0, r_angle};
                w_req.b  = {27'h0, r_acc};
            end
            S_LDIV, S_FDIV: begin
                w_req.a = w_rsp.q;
                w_req.b = 43'd100;
            end
            S_FLR: begin
                w_req.a = {18'h0, r_min_num};
                w_req.b = {27'h0, r_spd};
            end
            S_RDIV: begin
                w_req.a = {18'h0, r_root_num};
                w_req.b = {27'h0, r_acc};
            end
            S_SQRT: begin
                w_req.op = AOP_SQRT;
                w_req.a  = {18'h0, w_rsp.q[31:0]};
            end
            S_FMUL: begin
                w_req.op = AOP_MUL;
                w_req.a  = {18'h0, r_fscale};
                w_req.b  = {26'h0, w_rsp.q[16:0]};
            end
            S_SMUL: begin
                w_req.op = AOP_MUL;
                w_req.a  = {34'h0, r_spd};
                w_req.b  = {27'h0, r_spd};
            end
            S_TOP: begin
                w_req.a = w_rsp.q;
                w_req.b = {1'b0, r_lim};
            end
            S_NMUL: begin
                w_req.op = AOP_MUL;
                w_req.a  = {34'h0, r_n};
                w_req.b  = {27'h0, r_dec};
            end
            S_ALIM: begin
                w_req.a = w_rsp.q;
                w_req.b = {26'h0, {1'b0, r_acc} + {1'b0, r_dec}};
            end
            S_TMUL: begin
                w_req.op = AOP_MUL;
                w_req.a  = {18'h0, r_top};
                w_req.b  = {27'h0, r_acc};
            end
            S_BDIV: begin
                w_req.a = w_rsp.q;
                w_req.b = {27'h0, r_dec};
            end
            S_RDLY: begin
                w_req.a = {30'h0, w_num};
                w_req.b = {24'h0, w_dmag};
            end
            default: w_compute = 1'b0;
        endcase
        w_req.start = w_compute && !r_launched;
    end

    // sequencer and ramp state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_num   <= 32'd12566370;
            r_fscale    <= 32'd27040;
            r_root_num  <= 32'd628318530;
            r_angle     <= 32'd628;
            r_phase     <= PH_STOP;
            r_fwd       <= 1'b1;
            r_en        <= 1'b0;
            r_cur       <= '0;
            r_floor     <= '0;
            r_last      <= '0;
            r_bstart    <= '0;
            r_bneg      <= '0;
            r_cnt       <= '0;
            r_steps     <= '0;
            r_rem       <= '0;
            r_state     <= S_IDLE;
            r_launched  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MIN_DELAY_NUM: r_min_num  <= i_cfg_data;
                    REG_FIRST_SCALE:   r_fscale   <= i_cfg_data;
                    REG_ROOT_NUM:      r_root_num <= i_cfg_data;
                    REG_ANGLE_20K:     r_angle    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_req.start) r_launched <= 1'b1;
            if (w_rsp.done)  r_launched <= 1'b0;

            // output register
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_o_pulse   <= r_pulse;
                r_o_dir     <= r_fwd;
                r_o_period  <= r_period;
                r_o_run     <= r_en;
                r_o_bad     <= r_bad;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pulse  <= 1'b0;
                        r_bad    <= 1'b0;
                        r_period <= '0;
                        r_state  <= S_DONE;
                        if (i_cmd.operation) begin
                            // move command
                            r_n    <= w_n;
                            r_nfwd <= !i_cmd.move_steps[15];
                            r_acc  <= i_cmd.accel_rate;
                            r_dec  <= i_cmd.decel_rate;
                            r_spd  <= i_cmd.max_speed;
                            if (w_n == 16'd1) begin
                                r_fwd    <= !i_cmd.move_steps[15];
                                r_cnt    <= '1;
                                r_phase  <= PH_DECEL;
                                r_cur    <= 16'd4000;
                                r_en     <= 1'b1;
                                r_period <= 16'd2000;
                            end else if (w_n == 16'd0) begin
                                r_fwd <= !i_cmd.move_steps[15];
                            end else if (i_cmd.max_speed == '0 || i_cmd.accel_rate == '0) begin
                                r_bad <= 1'b1;
                            end else begin
                                r_state <= S_LMUL;
                            end
                        end else if (r_en) begin
                            // timer tick
                            r_period <= r_cur;
                            if (r_phase == PH_STOP) begin
                                r_steps <= '0;
                                r_rem   <= '0;
                                r_en    <= 1'b0;
                            end else begin
                                r_pulse <= 1'b1;
                                r_steps <= w_steps1;
                                if (r_phase == PH_RUN) begin
                                    if (ge_start(w_steps1, r_bstart)) begin
                                        r_cnt   <= r_bneg;
                                        r_cur   <= r_last;
                                        r_phase <= PH_DECEL;
                                    end else begin
                                        r_cur <= r_floor;
                                    end
                                end else begin
                                    r_cnt   <= r_cnt + 17'd1;
                                    r_state <= S_RDLY;
                                end
                            end
                        end
                    end
                end
                S_LMUL: if (w_rsp.done) r_state <= S_LDIV;
                S_LDIV: begin
                    if (w_rsp.done) begin
                        r_lim <= w_rsp.q[41:0];
                        if (w_rsp.q == '0) begin
                            r_bad   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_FLR;
                        end
                    end
                end
                S_FLR: begin
                    if (w_rsp.done) begin
                        r_floor <= sat16(w_rsp.q);
                        r_state <= S_RDIV;
                    end
                end
                S_RDIV: if (w_rsp.done) r_state <= S_SQRT;
                S_SQRT: if (w_rsp.done) r_state <= S_FMUL;
                S_FMUL: if (w_rsp.done) r_state <= S_FDIV;
                S_FDIV: begin
                    if (w_rsp.done) begin
                        r_first <= sat16(w_rsp.q);
                        r_state <= S_SMUL;
                    end
                end
                S_SMUL: if (w_rsp.done) r_state <= S_TOP;
                S_TOP: begin
                    if (w_rsp.done) begin
                        r_top   <= (w_rsp.q == '0) ? 32'd1 : w_rsp.q[31:0];
                        r_state <= S_NMUL;
                    end
                end
                S_NMUL: if (w_rsp.done) r_state <= S_ALIM;
                S_ALIM: begin
                    if (w_rsp.done) begin
                        r_state <= S_MFIN;
                        if (w_rsp.q == '0) begin
                            r_bl <= 17'd1 - {1'b0, r_n};
                        end else if ({18'h0, w_rsp.q[31:0]} <= {18'h0, r_top}) begin
                            r_bl <= {1'b0, w_rsp.q[15:0]} - {1'b0, r_n};
                        end else begin
                            r_state <= S_TMUL;
                        end
                    end
                end
                S_TMUL: if (w_rsp.done) r_state <= S_BDIV;
                S_BDIV: begin
                    // a zero brake length becomes one step
                    if (w_rsp.done) begin
                        r_bl    <= (w_rsp.q == '0) ? '1 : (17'd0 - w_rsp.q[16:0]);
                        r_state <= S_MFIN;
                    end
                end
                S_MFIN: begin
                    // commit the planned trapezoid
                    r_bneg   <= r_bl;
                    r_bstart <= {1'b0, r_n} + r_bl;
                    if (r_first <= r_floor) begin
                        r_cur   <= r_floor;
                        r_phase <= PH_RUN;
                    end else begin
                        r_cur   <= r_first;
                        r_phase <= PH_ACCEL;
                    end
                    r_fwd    <= r_nfwd;
                    r_cnt    <= '0;
                    r_en     <= 1'b1;
                    r_period <= 16'd2000;
                    r_state  <= S_DONE;
                end
                S_RDLY: begin
                    if (w_rsp.done) begin
                        r_rem   <= w_rsp.r[18:0];
                        r_cur   <= w_nd;
                        r_state <= S_DONE;
                        if (r_phase == PH_ACCEL) begin
                            if (ge_start(r_steps, r_bstart)) begin
                                r_cnt   <= r_bneg;
                                r_phase <= PH_DECEL;
                            end else if (w_nd <= r_floor) begin
                                r_last  <= w_nd;
                                r_cur   <= r_floor;
                                r_rem   <= '0;
                                r_phase <= PH_RUN;
                            end
                        end else if (!r_cnt[16]) begin
                            r_phase <= PH_STOP;
                        end
                    end
                end
                S_DONE: if (w_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    `ASSERT_IMPLY(a_off_is_stop, i_clk, i_rst_n, !r_en, r_phase == PH_STOP)
    `ASSERT_IMPLY(a_done_in_compute, i_clk, i_rst_n, w_rsp.done, w_compute && r_launched)
    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept, r_state != S_IDLE)

endmodule

// ----- src/stsr_arith.sv -----
// ----------------------------------------------------------------------------
// Serial arithmetic unit
// Shift-add multiply, restoring divide and integer square root, one bit
// (or one root digit) per cycle.
// ----------------------------------------------------------------------------
module stsr_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stsr_pkg::t_arith_req i_req,
    output stsr_pkg::t_arith_rsp o_rsp
);
    import stsr_pkg::*;

    logic              r_busy;
    logic              r_done;
    t_aop              r_op;
    logic [5:0]        r_cnt;
    logic [AR_A_W-1:0] r_acc;
    logic [AR_A_W-1:0] r_x;
    logic [AR_B_W-1:0] r_y;
    logic [AR_B_W:0]   r_rem;

    logic [AR_B_W:0]   w_t;
    logic              w_ge;
    logic [32:0]       w_sq_sum;
    logic              w_sq_fit;

    // divide trial and root trial
    always_comb begin
        w_t      = {r_rem[AR_B_W-1:0], r_x[AR_A_W-1]};
        w_ge     = w_t >= {1'b0, r_y};
        w_sq_sum = r_acc[32:0] + r_y[32:0];
        w_sq_fit = w_sq_sum <= r_rem[32:0];
    end

    // iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= AOP_DIV;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                case (i_req.op)
                    AOP_MUL: begin
                        r_cnt <= AR_MUL_STEPS;
                        r_acc <= '0;
                        r_x   <= i_req.a;
                        r_y   <= i_req.b;
                    end
                    AOP_SQRT: begin
                        r_cnt <= AR_SQRT_STEPS;
                        r_acc <= '0;
                        r_rem <= {{(AR_B_W-31){1'b0}}, i_req.a[31:0]};
                        r_y   <= {{(AR_B_W-31){1'b0}}, 31'h40000000};
                    end
                    default: begin
                        r_cnt <= AR_DIV_STEPS;
                        r_rem <= '0;
                        r_x   <= i_req.a;
                        r_y   <= i_req.b;
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    AOP_MUL: begin
                        if (r_y[0]) r_acc <= r_acc + r_x;
                        r_x <= {r_x[AR_A_W-2:0], 1'b0};
                        r_y <= {1'b0, r_y[AR_B_W-1:1]};
                    end
                    AOP_SQRT: begin
                        if (w_sq_fit) begin
                            r_rem <= r_rem - {{(AR_B_W-32){1'b0}}, w_sq_sum};
                            r_acc <= {1'b0, r_acc[AR_A_W-1:1]} +
                                     {{(AR_A_W-AR_B_W){1'b0}}, r_y};
                        end else begin
                            r_acc <= {1'b0, r_acc[AR_A_W-1:1]};
                        end
                        r_y <= {2'b00, r_y[AR_B_W-1:2]};
                    end
                    default: begin
                        r_rem <= w_ge ? (w_t - {1'b0, r_y}) : w_t;
                        r_x   <= {r_x[AR_A_W-2:0], w_ge};
                    end
                endcase
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // result select, root rounded up when the leftover exceeds it
    always_comb begin
        o_rsp.done = r_done;
        o_rsp.r    = r_rem[AR_B_W-1:0];
        case (r_op)
            AOP_MUL:  o_rsp.q = r_acc;
            AOP_SQRT: o_rsp.q = (r_acc[31:0] < r_rem[31:0]) ? r_acc + 1'b1 : r_acc;
            default:  o_rsp.q = r_x;
        endcase
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed ramp unit regression
// Drives move commands and timer ticks, predicts every result beat with an
// independent model of the ramp planner and checks each field in order.
// ----------------------------------------------------------------------------

// one expected result beat
typedef struct {
    bit        pulse;
    bit        dir;
    bit [15:0] period;
    bit        run;
    bit        bad;
} t_ramp_beat;

class t_ramp_scoreboard;
    bit [31:0]          regs [4];
    stsr_pkg::t_phase   phase;
    bit                 fwd;
    bit                 ten;
    bit [15:0]          cur;
    bit [15:0]          flo;
    bit [15:0]          last_ramp;
    longint             brk_start;
    longint             brk_neg;
    longint             ctr;
    bit [15:0]          done;
    bit [18:0]          rest;
    t_ramp_beat         expected_beats [$];
    int                 errors;

    function new();
        regs[0]   = 32'd12566370;
        regs[1]   = 32'd27040;
        regs[2]   = 32'd628318530;
        regs[3]   = 32'd628;
        phase     = stsr_pkg::PH_STOP;
        fwd       = 1'b1;
        ten       = 1'b0;
        cur       = '0;
        flo       = '0;
        last_ramp = '0;
        brk_start = 0;
        brk_neg   = 0;
        ctr       = 0;
        done      = '0;
        rest      = '0;
        errors    = 0;
    endfunction

    function void set_reg(bit [1:0] idx, bit [31:0] val);
        regs[idx] = val;
    endfunction

    // sign-fold into 17 bits
    function longint fold17(longint v);
        logic signed [16:0] t;
        t = v[16:0];
        return t;
    endfunction

    function bit [15:0] clamp16(longint v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    // rounded integer square root
    function longint unsigned isqrt_round(bit [31:0] v);
        longint unsigned x, r, b;
        x = v;
        r = 0;
        b = 64'h40000000;
        while (b != 0) begin
            if (r + b <= x) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return (r < x) ? r + 1 : r;
    endfunction

    // delay recurrence with remainder carry
    function bit [15:0] next_delay();
        longint d, num, q;
        d    = 4 * ctr + 1;
        num  = 2 * longint'(cur) + longint'(rest);
        q    = num / d;
        rest = 19'(num - q * d);
        return clamp16(longint'(cur) - q);
    endfunction

    function bit running();
        return ten;
    endfunction

    function int pending();
        return expected_beats.size();
    endfunction

    // predict the result of one accepted command beat
    function void note_command(bit op, bit [15:0] steps, bit [15:0] acc_in,
                               bit [15:0] dec_in, bit [15:0] spd_in);
        t_ramp_beat        e;
        longint            s, bl;
        longint unsigned   n, acc, dec, spd, lim, top, accl, first;
        bit [15:0]         nd;
        e = '{default: 0};
        if (op) begin
            s   = longint'($signed(steps));
            n   = (s < 0) ? -s : s;
            acc = acc_in;
            dec = dec_in;
            spd = spd_in;
            if (n == 1) begin
                fwd   = (s >= 0);
                ctr   = -1;
                phase = stsr_pkg::PH_DECEL;
                cur   = 16'd4000;
                ten   = 1'b1;
                e.period = 16'd2000;
            end else if (n == 0) begin
                fwd = (s >= 0);
            end else begin
                lim = (acc * regs[3]) / 100;
                if (spd == 0 || acc == 0 || lim == 0) begin
                    e.bad = 1'b1;
                end else begin
                    fwd   = (s >= 0);
                    flo   = clamp16(longint'(regs[0] / spd));
                    first = (longint'(regs[1]) * isqrt_round(32'(regs[2] / acc))) / 100;
                    top   = spd * spd / lim;
                    if (top == 0) top = 1;
                    accl  = (n * dec) / (acc + dec);
                    if (accl == 0) accl = 1;
                    if (accl <= top) bl = longint'(accl) - longint'(n);
                    else bl = -longint'((top * acc) / dec);
                    if (bl == 0) bl = -1;
                    brk_neg   = fold17(bl);
                    brk_start = fold17(longint'(n) + bl);
                    cur       = clamp16(longint'(first));
                    if (cur <= flo) begin
                        cur   = flo;
                        phase = stsr_pkg::PH_RUN;
                    end else begin
                        phase = stsr_pkg::PH_ACCEL;
                    end
                    ctr = 0;
                    ten = 1'b1;
                    e.period = 16'd2000;
                end
            end
        end else if (ten) begin
            nd       = cur;
            e.period = cur;
            if (phase == stsr_pkg::PH_STOP) begin
                done = '0;
                rest = '0;
                ten  = 1'b0;
            end else begin
                e.pulse = 1'b1;
                done    = done + 16'd1;
                if (phase == stsr_pkg::PH_ACCEL) begin
                    ctr = fold17(ctr + 1);
                    nd  = next_delay();
                    if (longint'(done) >= brk_start) begin
                        ctr   = brk_neg;
                        phase = stsr_pkg::PH_DECEL;
                    end else if (nd <= flo) begin
                        last_ramp = nd;
                        nd        = flo;
                        rest      = '0;
                        phase     = stsr_pkg::PH_RUN;
                    end
                end else if (phase == stsr_pkg::PH_RUN) begin
                    nd = flo;
                    if (longint'(done) >= brk_start) begin
                        ctr   = brk_neg;
                        nd    = last_ramp;
                        phase = stsr_pkg::PH_DECEL;
                    end
                end else begin
                    ctr = fold17(ctr + 1);
                    nd  = next_delay();
                    if (ctr >= 0) phase = stsr_pkg::PH_STOP;
                end
            end
            cur = nd;
        end
        e.dir = fwd;
        e.run = ten;
        expected_beats.push_back(e);
    endfunction

    task report(string what, int got, int want);
        errors++;
        if (errors <= 40)
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    // compare one accepted result beat with the oldest expectation
    task check_result(bit pulse, bit dir, bit [15:0] period, bit run, bit bad);
        t_ramp_beat e;
        if (expected_beats.size() == 0) begin
            report("unexpected result beat", 1, 0);
            return;
        end
        e = expected_beats.pop_front();
        if (pulse !== e.pulse) report("step_pulse", pulse, e.pulse);
        if (dir !== e.dir) report("direction_out", dir, e.dir);
        if (period !== e.period) report("timer_period", period, e.period);
        if (run !== e.run) report("running", run, e.run);
        if (bad !== e.bad) report("bad_command", bad, e.bad);
    endtask
endclass

module testbench;
    import stsr_pkg::*;

    localparam bit OP_TICK = 1'b0;
    localparam bit OP_MOVE = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    stsr_cmd_if cmd_ch ();
    stsr_res_if res_ch ();

    stepper_trapezoid_speed_ramp_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch)
    );

    t_ramp_scoreboard sb;
    int             send_idle;
    int             recv_stall;
    bit             hold_on;
    int             hold_cnt;
    int             sent;

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side back-pressure, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_cnt     <= 0;
        end else if (hold_on && hold_cnt < 3000) begin
            res_ch.ready <= 1'b0;
            hold_cnt     <= hold_cnt + 1;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.step_pulse, res_ch.direction_out, res_ch.timer_period,
                            res_ch.running, res_ch.bad_command);
    end

    // run limit
    initial begin
        #80ms;
        $display("Regression FAIL");
        $finish;
    end

    task write_reg(bit [1:0] idx, bit [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task send_beat(bit op, bit [15:0] steps, bit [15:0] acc, bit [15:0] dec,
                   bit [15:0] spd);
        while ($urandom_range(99) < send_idle) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.operation  <= op;
        cmd_ch.move_steps <= steps;
        cmd_ch.accel_rate <= acc;
        cmd_ch.decel_rate <= dec;
        cmd_ch.max_speed  <= spd;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_command(op, steps, acc, dec, spd);
        sent++;
    endtask

    task tick_until_stop(int max_ticks);
        int k;
        k = 0;
        while (sb.running() && k < max_ticks) begin
            send_beat(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            k++;
        end
    endtask

    // wait for every expected beat, then let the block settle
    task drain();
        cmd_ch.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // one planned move with random content, followed by its ticks
    task move_sequence();
        int          pick;
        bit [15:0]   steps;
        pick = $urandom_range(99);
        if (pick < 70) steps = 16'($urandom_range(2, 60));
        else if (pick < 80) steps = 16'($urandom_range(0, 1));
        else if (pick < 90) steps = 16'($urandom_range(61, 32767));
        else steps = 16'h8000;
        if ($urandom_range(1)) steps = -steps;
        send_beat(OP_MOVE, steps, 16'($urandom_range(1, 4000)),
                  16'($urandom_range(0, 4000)), 16'($urandom_range(1, 4000)));
        tick_until_stop($urandom_range(5, 150));
    endtask

    initial begin
        bit [31:0] cfg_set [4];
        sb           = new();
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.operation  = 1'b0;
        cmd_ch.move_steps = '0;
        cmd_ch.accel_rate = '0;
        cmd_ch.decel_rate = '0;
        cmd_ch.max_speed  = '0;
        send_idle    = 0;
        recv_stall   = 0;
        hold_on      = 1'b0;
        sent         = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: timer off, zero step, zero divisors, single step
        send_beat(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_MOVE, 16'h0000, 16'd500, 16'd500, 16'd500);
        send_beat(OP_MOVE, 16'd10, 16'd500, 16'd500, 16'd0);
        send_beat(OP_MOVE, 16'd10, 16'd0, 16'd500, 16'd500);
        send_beat(OP_MOVE, 16'hFFFF, 16'd500, 16'd500, 16'd500);
        tick_until_stop(4);
        // extremes, new move while running, most negative steps
        send_beat(OP_MOVE, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        tick_until_stop(3);
        send_beat(OP_MOVE, 16'h8000, 16'd1, 16'd0, 16'd1);
        tick_until_stop(3);
        // run entered directly on a short move
        send_beat(OP_MOVE, 16'd3, 16'd1000, 16'd1000, 16'd1);
        tick_until_stop(8);
        drain();
        // divisor from the angle register rounding to zero
        write_reg(REG_ANGLE_20K, 32'd1);
        send_beat(OP_MOVE, 16'd20, 16'd50, 16'd50, 16'd50);
        drain();

        // random phases over settings and idle patterns
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                1: cfg_set = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
                2: cfg_set = '{32'd1, 32'd1, 32'd1, 32'd1};
                4: cfg_set = '{$urandom_range(1, 32'h7FFFFFF), $urandom_range(1, 200000),
                               $urandom, $urandom_range(1, 5000)};
                default: cfg_set = '{32'd12566370, 32'd27040, 32'd628318530, 32'd628};
            endcase
            write_reg(REG_MIN_DELAY_NUM, cfg_set[0]);
            write_reg(REG_FIRST_SCALE, cfg_set[1]);
            write_reg(REG_ROOT_NUM, cfg_set[2]);
            write_reg(REG_ANGLE_20K, cfg_set[3]);
            case (ph)
                1: begin send_idle = 85; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 85; end
                3: begin send_idle = 6;  recv_stall = 6;  end
                5: begin send_idle = 85; recv_stall = 85; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            sent = 0;
            while (sent < 180) begin
                if (ph == 4 && sent > 60) hold_on = 1'b1;
                if (ph == 3 && sent > 100 && sent < 110) begin
                    drain();
                end
                if ($urandom_range(99) < 80) begin
                    move_sequence();
                end else begin
                    send_beat(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
                end
            end
        end

        drain();
        repeat (600) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
